// ===== rtl/rrp_pkg.sv =====
// shared types and constants for the round robin process ring
// used by rrp_ctrl, rrp_dpath and round_robin_process_ring; no dependencies
package rrp_pkg;

  localparam int RRP_DEPTH = 16;

  localparam int FIELD_W  = 16;
  localparam int OPCODE_W = 3;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;
  localparam int HELD_W   = 5;

  typedef enum logic [2:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_TICK      = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_HEAD = 3'd1,
    RD_TAIL = 3'd2,
    RD_IDX  = 3'd3,
    RD_IDX1 = 3'd4
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    push;
    rd_sel_t rd_sel;
    logic    commit;
    logic    idx_clr;
    logic    idx_inc;
    logic    take;
    logic    shift_wr;
    logic    dec_occ;
    logic    set_err;
    status_t err_code;
    logic    out_load;
  } rrp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                empty;
    logic                full;
    logic                hit;
    logic                idx_last;
    logic                idx_last2;
    logic                out_free;
  } rrp_sts_t;

endpackage

// ===== rtl/rrp_ctrl.sv =====
// sequencer for the process ring: accepts an item and steps the datapath
// through push, pop, tick, match search and close-up; depends on rrp_pkg
module rrp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  rrp_pkg::rrp_sts_t sts,
  output rrp_pkg::rrp_cmd_t cmd
);
  import rrp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op) inside
          OP_PUSH_TAIL, OP_PUSH_HEAD: state_nxt = S_DONE;
          OP_POP_HEAD, OP_POP_TAIL, OP_TICK: begin
            state_nxt = sts.empty ? S_DONE : S_POP_WAIT;
          end
          OP_REMOVE: begin
            state_nxt = sts.empty ? S_DONE : S_SCAN_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_POP_WAIT: state_nxt = S_DONE;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts.hit) begin
          state_nxt = sts.idx_last ? S_DONE : S_SHIFT_RD;
        end else begin
          state_nxt = sts.idx_last ? S_DONE : S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = sts.idx_last2 ? S_DONE : S_SHIFT_RD;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    cmd.err_code = ST_OK;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      S_EXEC: begin
        unique case (sts.op) inside
          OP_PUSH_TAIL, OP_PUSH_HEAD: begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP_HEAD, OP_POP_TAIL, OP_TICK: begin
            if (sts.empty) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_EMPTY;
            end else begin
              cmd.rd_sel = (sts.op == OP_POP_TAIL) ? RD_TAIL : RD_HEAD;
            end
          end
          OP_REMOVE: begin
            if (sts.empty) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_EMPTY;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POP_WAIT: cmd.commit = 1'b1;
      S_SCAN_RD:  cmd.rd_sel = RD_IDX;
      S_SCAN_CMP: begin
        if (sts.hit) begin
          cmd.take    = 1'b1;
          cmd.dec_occ = sts.idx_last;
        end else if (sts.idx_last) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_NOMATCH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT_RD: cmd.rd_sel = RD_IDX1;
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        cmd.dec_occ  = sts.idx_last2;
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rrp_dpath.sv =====
// datapath of the process ring: entry memory, head and count, scan index,
// result and output register; depends on rrp_pkg
module rrp_dpath #(
  parameter int DEPTH = rrp_pkg::RRP_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [rrp_pkg::IN_W-1:0] in_tdata,
  input  rrp_pkg::rrp_cmd_t        cmd,
  output rrp_pkg::rrp_sts_t        sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [rrp_pkg::OUT_W-1:0] out_tdata
);
  import rrp_pkg::*;

  localparam int HW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int WW = 2 * FIELD_W;
  localparam logic [HW:0]   DEPTH_S  = (HW + 1)'(DEPTH);
  localparam logic [HW-1:0] LAST_IDX = HW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_CNT = OW'(DEPTH);

  logic [WW-1:0] mem [DEPTH];

  logic [OPCODE_W-1:0] op_r;
  logic [FIELD_W-1:0]  pid_r, load_r;
  logic [HW-1:0]       head_r, head_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [HW-1:0]       idx_r;
  logic [WW-1:0]       rd_data_r;
  status_t             res_status_r;
  logic [FIELD_W-1:0]  res_pid_r, res_load_r;
  logic                res_fin_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic [HW-1:0]      head_inc, head_dec, rd_addr, wr_addr, idx_p1;
  logic [OW-1:0]      occ_m1;
  logic               rd_en, wr_en;
  logic [WW-1:0]      wr_data;
  logic [FIELD_W-1:0] rd_pid, rd_load, dec_load;
  logic [OW:0]        idx_ext, occ_ext;
  logic [OW+HELD_W-1:0] held_ext;

  // ring position base + off, both below DEPTH
  function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] base,
                                             input logic [HW-1:0] off);
    logic [HW:0] s;
    logic [HW:0] t;
    s = {1'b0, base} + {1'b0, off};
    t = s - DEPTH_S;
    return (s >= DEPTH_S) ? t[HW-1:0] : s[HW-1:0];
  endfunction

  assign rd_pid   = rd_data_r[WW-1:FIELD_W];
  assign rd_load  = rd_data_r[FIELD_W-1:0];
  assign dec_load = (rd_load != '0) ? rd_load - 1'b1 : '0;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign occ_m1   = occ_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;
  assign idx_ext  = {1'b0, OW'(idx_r)};
  assign occ_ext  = {1'b0, occ_r};

  assign sts.op        = op_r;
  assign sts.empty     = (occ_r == '0);
  assign sts.full      = (occ_r >= FULL_CNT);
  assign sts.hit       = (rd_data_r == {pid_r, load_r});
  assign sts.idx_last  = (idx_ext + 1'b1 >= occ_ext);
  assign sts.idx_last2 = (idx_ext + 2'd2 >= occ_ext);
  assign sts.out_free  = !out_valid_r || out_tready;

  // read port select
  always_comb begin
    rd_en = 1'b1;
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TAIL: rd_addr = wrap_add(head_r, occ_m1[HW-1:0]);
      RD_IDX:  rd_addr = wrap_add(head_r, idx_r);
      RD_IDX1: rd_addr = wrap_add(head_r, idx_p1);
      default: begin
        rd_en   = 1'b0;
        rd_addr = head_r;
      end
    endcase
  end

  // write port: push, tick write-back or close-up move
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_r;
    wr_data = {pid_r, load_r};
    if (cmd.push) begin
      wr_en   = 1'b1;
      wr_addr = (op_r == OP_PUSH_TAIL) ? wrap_add(head_r, occ_r[HW-1:0]) : head_dec;
    end else if (cmd.commit && op_r == OP_TICK) begin
      wr_en   = 1'b1;
      wr_data = {rd_pid, dec_load};
    end else if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = wrap_add(head_r, idx_r);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    if (cmd.push) begin
      occ_nxt = occ_r + 1'b1;
      if (op_r == OP_PUSH_HEAD) head_nxt = head_dec;
    end
    if (cmd.commit) begin
      if (op_r != OP_POP_TAIL) head_nxt = head_inc;
      if (op_r != OP_TICK || dec_load == '0) occ_nxt = occ_m1;
    end
    if (cmd.dec_occ) occ_nxt = occ_m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign held_ext = {{HELD_W{1'b0}}, occ_r};

  // payload: item fields, scan index and result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r         <= in_tdata[OPCODE_W-1:0];
      pid_r        <= in_tdata[OPCODE_W +: FIELD_W];
      load_r       <= in_tdata[OPCODE_W+FIELD_W +: FIELD_W];
      res_status_r <= ST_OK;
      res_pid_r    <= '0;
      res_load_r   <= '0;
      res_fin_r    <= 1'b0;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end
    if (cmd.set_err) res_status_r <= cmd.err_code;
    if (cmd.take) begin
      res_pid_r  <= rd_pid;
      res_load_r <= rd_load;
    end
    if (cmd.commit) begin
      res_pid_r <= rd_pid;
      if (op_r == OP_TICK) begin
        res_load_r <= dec_load;
        res_fin_r  <= (dec_load == '0);
      end else begin
        res_load_r <= rd_load;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {held_ext[HELD_W-1:0], res_fin_r, res_load_r, res_pid_r,
                     res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/round_robin_process_ring.sv =====
// round robin process ring, top level: sequencer plus datapath
// depends on rrp_pkg, rrp_ctrl and rrp_dpath
//
// Keeps a circular order of up to DEPTH process entries (pid, remaining load)
// in an entry memory with separate read and write ports and a registered
// read. One item is handled at a time: an item is taken, then its result is
// loaded into the output register, which may still hold the previous result
// while the next item is taken. A match removal reads entries from the head
// one at a time until it finds the match, then closes up the later entries,
// each with one memory read and one write; a search that finds no match
// reads every entry. A result still waiting in the output register holds
// the sequencer.
// The memory needs no clearing after reset.
module round_robin_process_ring #(
  parameter int DEPTH = rrp_pkg::RRP_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // opcode [2:0], item_pid [18:3], item_load [34:19], zero [39:35]
  input  logic [rrp_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status [1:0], out_pid [17:2], out_load [33:18], finished [34],
  // entries_held [39:35]
  output logic [rrp_pkg::OUT_W-1:0] out_tdata
);
  import rrp_pkg::*;

  rrp_cmd_t cmd;
  rrp_sts_t sts;

  rrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrp_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while another is in flight");

  // a result never overwrites one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // no push into a full ring
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push into full ring");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench for round_robin_process_ring: directed and random opcode items,
// each result checked against a behavioral model of the ring kept here
// depends on rrp_pkg and the round_robin_process_ring rtl
module tb;
  import rrp_pkg::*;

  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [15:0] pid;
    logic [15:0] load;
    logic        finished;
    logic [4:0]  held;
  } ring_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // model of the ring
  logic [15:0]  ring_pid [RRP_DEPTH];
  logic [15:0]  ring_load [RRP_DEPTH];
  int           ring_head;
  int           ring_count;
  ring_result_t pending_results[$];

  int error_count;
  int checked_count;
  int item_count;
  int send_idle_pct;
  int recv_stall_pct;
  int status_seen [4];
  int finish_seen;

  round_robin_process_ring i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // applies one item to the ring model and returns the result it should give
  function automatic ring_result_t ring_apply(logic [2:0] op, logic [15:0] pid,
                                              logic [15:0] load);
    ring_result_t r;
    int k;
    int i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (ring_count >= RRP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_TAIL) begin
            k = (ring_head + ring_count) % RRP_DEPTH;
          end else begin
            ring_head = (ring_head + RRP_DEPTH - 1) % RRP_DEPTH;
            k = ring_head;
          end
          ring_pid[k]  = pid;
          ring_load[k] = load;
          ring_count++;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = (op == OP_POP_HEAD) ? ring_head : (ring_head + ring_count - 1) % RRP_DEPTH;
          r.pid  = ring_pid[k];
          r.load = ring_load[k];
          if (op == OP_POP_HEAD) ring_head = (ring_head + 1) % RRP_DEPTH;
          ring_count--;
        end
      end
      OP_REMOVE: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          i = 0;
          while (i < ring_count && !(ring_pid[(ring_head + i) % RRP_DEPTH] == pid &&
                                     ring_load[(ring_head + i) % RRP_DEPTH] == load))
            i++;
          if (i == ring_count) begin
            r.status = ST_NOMATCH;
          end else begin
            k = (ring_head + i) % RRP_DEPTH;
            r.pid  = ring_pid[k];
            r.load = ring_load[k];
            // later entries close up toward the head
            for (; i + 1 < ring_count; i++) begin
              ring_pid[(ring_head + i) % RRP_DEPTH]  = ring_pid[(ring_head + i + 1) % RRP_DEPTH];
              ring_load[(ring_head + i) % RRP_DEPTH] = ring_load[(ring_head + i + 1) % RRP_DEPTH];
            end
            ring_count--;
          end
        end
      end
      OP_TICK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = ring_head;
          if (ring_load[k] != 0) ring_load[k] = ring_load[k] - 16'd1;
          r.pid  = ring_pid[k];
          r.load = ring_load[k];
          ring_head = (ring_head + 1) % RRP_DEPTH;
          if (ring_load[k] == 0) begin
            r.finished = 1'b1;
            ring_count--;
          end
        end
      end
      default: ;
    endcase
    r.held = 5'(ring_count);
    return r;
  endfunction

  task automatic send_item(logic [2:0] op, logic [15:0] pid, logic [15:0] load);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, load, pid, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(ring_apply(op, pid, load));
    item_count++;
    @(negedge clk);
  endtask

  task automatic wait_ring_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result %h arrived with nothing expected", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        status_seen[want.status]++;
        if (want.finished) finish_seen++;
        check_field("status", 16'(want.status), 16'(out_tdata[1:0]));
        check_field("out_pid", want.pid, out_tdata[17:2]);
        check_field("out_load", want.load, out_tdata[33:18]);
        check_field("finished", 16'(want.finished), 16'(out_tdata[34]));
        check_field("entries_held", 16'(want.held), 16'(out_tdata[39:35]));
      end
    end
  end

  function automatic logic [15:0] pick_pid();
    if ($urandom_range(99) < 35) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_load();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom_range(3));
    if (r < 85) return 16'($urandom_range(40, 4));
    return 16'($urandom);
  endfunction

  task automatic test_empty_ring();
    send_item(OP_POP_HEAD, 16'h0000, 16'h0000);
    send_item(OP_POP_TAIL, 16'hffff, 16'hffff);
    send_item(OP_REMOVE, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_SPARE_6, 16'hffff, 16'hffff);
  endtask

  task automatic test_push_pop_ends();
    send_item(OP_PUSH_TAIL, 16'hffff, 16'hffff);
    send_item(OP_PUSH_HEAD, 16'h0000, 16'h0000);
    send_item(OP_POP_TAIL, 16'h0000, 16'h0000);
    send_item(OP_POP_HEAD, 16'h0000, 16'h0000);
    send_item(OP_SPARE_7, 16'h5a5a, 16'ha5a5);
    send_item(OP_PUSH_TAIL, 16'hffff, 16'hffff);
    send_item(OP_PUSH_HEAD, 16'h0000, 16'h0000);
  endtask

  task automatic test_remove_match();
    send_item(OP_PUSH_TAIL, 16'h1234, 16'h0001);
    send_item(OP_PUSH_TAIL, 16'h1234, 16'h0001);
    send_item(OP_PUSH_TAIL, 16'h5678, 16'h0009);
    // pid matches but load does not
    send_item(OP_REMOVE, 16'h1234, 16'h0002);
    // duplicates: only the first one goes
    send_item(OP_REMOVE, 16'h1234, 16'h0001);
    send_item(OP_REMOVE, 16'h5678, 16'h0009);
  endtask

  task automatic test_tick_service();
    // zero load at head finishes at once, then a rotate, then 1 -> 0 finishes
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_POP_HEAD, 16'h0000, 16'h0000);
  endtask

  // alternates between filling and draining so both full and empty are hit
  task automatic test_random_mix(int idle_pct, int stall_pct, int count);
    int n;
    int mode_left;
    int r;
    int k;
    bit fill;
    logic [2:0] op;
    logic [15:0] pid;
    logic [15:0] load;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    fill      = 1'b1;
    mode_left = $urandom_range(60, 20);
    for (n = 0; n < count; n++) begin
      if (mode_left == 0) begin
        fill      = !fill;
        mode_left = $urandom_range(60, 20);
      end
      mode_left--;
      r    = $urandom_range(99);
      pid  = pick_pid();
      load = pick_load();
      if (r < (fill ? 60 : 15)) begin
        op = $urandom_range(1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
      end else if (r < (fill ? 66 : 40)) begin
        op = $urandom_range(1) ? OP_POP_HEAD : OP_POP_TAIL;
      end else if (r < (fill ? 74 : 60)) begin
        op = OP_REMOVE;
        // mostly aim at a held entry, now and then one load off
        if (ring_count != 0 && $urandom_range(99) < 80) begin
          k    = (ring_head + $urandom_range(ring_count - 1)) % RRP_DEPTH;
          pid  = ring_pid[k];
          load = ring_load[k];
          if ($urandom_range(99) < 15) load = load + 16'd1;
        end
      end else if (r < (fill ? 96 : 97)) begin
        op = OP_TICK;
      end else begin
        op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      send_item(op, pid, load);
    end
    wait_ring_idle();
  endtask

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    checked_count  = 0;
    item_count     = 0;
    finish_seen    = 0;
    ring_head      = 0;
    ring_count     = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_ring();
    test_push_pop_ends();
    test_remove_match();
    test_tick_service();
    wait_ring_idle();

    test_random_mix(0, 0, 285);
    test_random_mix(75, 0, 285);
    test_random_mix(0, 75, 285);
    test_random_mix(38, 38, 285);

    repeat (60) @(posedge clk);
    $display("sent %0d items, checked %0d results under four idle/stall mixes",
             item_count, checked_count);
    $display("outcomes: %0d ok, %0d empty, %0d full, %0d no match, %0d finished",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_NOMATCH], finish_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
